/* rtl/ccs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants, codes, types and helpers of the channel continuity scanner.
// ----------------------------------------------------------------------------
package ccs_pkg;

    // Scan geometry
    localparam int NUM_CHANNELS = 16;
    localparam int SAMPLE_TICKS = 6;

    // Field and state widths
    localparam int SAMPLE_W  = 18;
    localparam int SUM_W     = 21;
    localparam int MARKER_W  = 2;
    localparam int ENTRY_W   = SUM_W + MARKER_W;
    localparam int MASK_W    = 16;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SCAN_W    = $clog2(NUM_CHANNELS + 1);
    localparam int CNT_W     = $clog2(SAMPLE_TICKS + 1);

    // Average = sum / (SAMPLE_TICKS - 1), done as a reciprocal multiply
    localparam int DIVISOR   = SAMPLE_TICKS - 1;
    localparam int DIV_SHIFT = SUM_W + 4;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OK_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OK_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IND_ENABLE = 3'd4;

    // Configuration reset values
    localparam logic [SAMPLE_W-1:0] OK_LOW_RST  = 18'd125;
    localparam logic [SAMPLE_W-1:0] OK_HIGH_RST = 18'd14000;
    localparam logic [SAMPLE_W-1:0] OPEN_RST    = 18'd100000;
    localparam logic [MASK_W-1:0]   NEEDED_RST  = 16'd57615;

    // Result kinds
    localparam logic KIND_DRIVE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Verdicts
    localparam logic [1:0] VERDICT_FAULT = 2'd0;
    localparam logic [1:0] VERDICT_OK    = 2'd1;
    localparam logic [1:0] VERDICT_OPEN  = 2'd2;

    // Indicator colours
    localparam logic [1:0] COLOUR_OFF    = 2'd0;
    localparam logic [1:0] COLOUR_RED    = 2'd1;
    localparam logic [1:0] COLOUR_GREEN  = 2'd2;
    localparam logic [1:0] COLOUR_YELLOW = 2'd3;

    // Display markers
    localparam logic [MARKER_W-1:0] MARKER_BLINK_RED   = 2'd0;
    localparam logic [MARKER_W-1:0] MARKER_BLINK_GREEN = 2'd1;
    localparam logic [MARKER_W-1:0] MARKER_DARK        = 2'd2;
    localparam logic [MARKER_W-1:0] MARKER_STEADY      = 2'd3;

    // Per-channel report from the classifier
    typedef struct packed {
        logic [1:0]          verdict;
        logic                led_write;
        logic [1:0]          led_colour;
        logic [MARKER_W-1:0] marker;
    } report_t;

    // Channel field of a result: index modulo 16
    function automatic logic [3:0] chan_field(input logic [IDX_W-1:0] idx);
        logic [IDX_W+3:0] w;
        w = {4'd0, idx};
        return w[3:0];
    endfunction

    // Channels at 16 and above are never needed
    function automatic logic chan_needed(input logic [MASK_W-1:0] mask,
                                         input logic [IDX_W-1:0]  idx);
        logic [IDX_W+3:0] w;
        w = {4'd0, idx};
        return (w[IDX_W+3:4] == '0) && mask[w[3:0]];
    endfunction

endpackage

/* rtl/ccs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ccs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                            aclk,
    input  logic                                            we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
    input  logic [DATA_W-1:0]                               wdata,
    input  logic                                            re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
    output logic [DATA_W-1:0]                               rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ccs_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_classify
// Average one channel sum, grade it and work out the indicator colour.
// ----------------------------------------------------------------------------
module ccs_classify (
    input  logic [ccs_pkg::SUM_W-1:0]    sum,
    input  logic [ccs_pkg::MARKER_W-1:0] marker_old,
    input  logic                         needed,
    input  logic                         ind_enable,
    input  logic                         blink_phase,
    input  logic [ccs_pkg::SAMPLE_W-1:0] ok_low_limit,
    input  logic [ccs_pkg::SAMPLE_W-1:0] ok_high_limit,
    input  logic [ccs_pkg::SAMPLE_W-1:0] open_limit,
    output ccs_pkg::report_t             report
);

    logic [ccs_pkg::PROD_W-1:0] prod;
    logic [ccs_pkg::SUM_W-1:0]  avg;
    logic [ccs_pkg::SUM_W-1:0]  low_ext;
    logic [ccs_pkg::SUM_W-1:0]  high_ext;
    logic [ccs_pkg::SUM_W-1:0]  open_ext;

    // Truncating divide by a constant through its scaled reciprocal
    assign prod     = ccs_pkg::PROD_W'(sum) * ccs_pkg::PROD_W'(ccs_pkg::RECIP);
    assign avg      = prod[ccs_pkg::DIV_SHIFT +: ccs_pkg::SUM_W];
    assign low_ext  = ccs_pkg::SUM_W'(ok_low_limit);
    assign high_ext = ccs_pkg::SUM_W'(ok_high_limit);
    assign open_ext = ccs_pkg::SUM_W'(open_limit);

    always_comb begin
        report            = '0;
        report.marker     = marker_old;
        report.led_colour = ccs_pkg::COLOUR_OFF;

        if ((avg < high_ext) && (avg > low_ext)) begin
            report.verdict = ccs_pkg::VERDICT_OK;
        end else begin
            report.verdict = ccs_pkg::VERDICT_FAULT;
        end
        if (avg > open_ext) begin
            report.verdict = ccs_pkg::VERDICT_OPEN;
        end

        if (ind_enable) begin
            if (needed) begin
                report.led_write = 1'b1;
                report.marker    = ccs_pkg::MARKER_STEADY;
                case (report.verdict)
                    ccs_pkg::VERDICT_FAULT: report.led_colour = ccs_pkg::COLOUR_RED;
                    ccs_pkg::VERDICT_OK:    report.led_colour = ccs_pkg::COLOUR_GREEN;
                    default:                report.led_colour = ccs_pkg::COLOUR_YELLOW;
                endcase
            end else begin
                report.marker = report.verdict;
            end
        end

        // Blink step on the (possibly stale) marker
        case (report.marker)
            ccs_pkg::MARKER_BLINK_RED: begin
                report.led_write  = 1'b1;
                report.led_colour = blink_phase ? ccs_pkg::COLOUR_RED : ccs_pkg::COLOUR_OFF;
            end
            ccs_pkg::MARKER_BLINK_GREEN: begin
                report.led_write  = 1'b1;
                report.led_colour = blink_phase ? ccs_pkg::COLOUR_GREEN
                                                : ccs_pkg::COLOUR_OFF;
            end
            ccs_pkg::MARKER_DARK: begin
                report.led_write  = 1'b1;
                report.led_colour = ccs_pkg::COLOUR_OFF;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/channel_continuity_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_continuity_scanner
// Scans the channels in turn, sums their resistance samples in a channel RAM
// and, once per sweep, grades every channel and reports its indicator colour.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    sample_mohm (18 bit)
//  m_        out        m_valid/m_ready    kind, channel, drive, verdict,
//                                          led_write, led_colour, last
//  cfg_      in         cfg_we             cfg_index (3 bit), cfg_wdata (18 bit)
//
//  In a scan item the channel RAM is read on accept; in ST_SCAN, once the
//  output is free, the sum is written back if the tick adds to it and the result is loaded.
//  The sweep-end item gives one report a cycle while m_ready holds, the
//  RAM reading channel i+1 while channel i is graded and written back.
//  Reset (synchronous, aresetn low) clears the control state and the RAM
//  valid bits, so no clearing pass is needed; unwritten entries read as zero.
//  A stalled m_ready holds the current report and freezes the sweep.
//
module channel_continuity_scanner (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ccs_pkg::SAMPLE_W-1:0] s_sample_mohm,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_kind,
    output logic [3:0]                   m_channel,
    output logic                         m_drive,
    output logic [1:0]                   m_verdict,
    output logic                         m_led_write,
    output logic [1:0]                   m_led_colour,
    output logic                         m_last,

    input  logic                          cfg_we,
    input  logic [ccs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ccs_pkg::CFG_W-1:0]     cfg_wdata
);

    // Sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    // Configuration registers
    logic [ccs_pkg::SAMPLE_W-1:0] ok_low_reg;
    logic [ccs_pkg::SAMPLE_W-1:0] ok_high_reg;
    logic [ccs_pkg::SAMPLE_W-1:0] open_reg;
    logic [ccs_pkg::MASK_W-1:0]   needed_reg;
    logic                         ind_enable_reg;

    // Control state
    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [ccs_pkg::SCAN_W-1:0]   scan_channel_reg;
    logic [ccs_pkg::SCAN_W-1:0]   scan_channel_next;
    logic [ccs_pkg::CNT_W-1:0]    sample_count_reg;
    logic [ccs_pkg::CNT_W-1:0]    sample_count_next;
    logic [ccs_pkg::IDX_W-1:0]    sweep_idx_reg;
    logic [ccs_pkg::IDX_W-1:0]    sweep_idx_next;
    logic                         blink_phase_reg;
    logic                         blink_phase_next;
    logic [ccs_pkg::SAMPLE_W-1:0] sample_reg;
    logic [ccs_pkg::NUM_CHANNELS-1:0] entry_valid_reg;
    logic                         rd_valid_reg;

    // Output register
    logic                         m_valid_reg;
    logic                         m_kind_reg;
    logic [3:0]                   m_channel_reg;
    logic                         m_drive_reg;
    logic [1:0]                   m_verdict_reg;
    logic                         m_led_write_reg;
    logic [1:0]                   m_led_colour_reg;
    logic                         m_last_reg;

    // Channel RAM ports
    logic                         ram_we;
    logic [ccs_pkg::IDX_W-1:0]    ram_waddr;
    logic [ccs_pkg::ENTRY_W-1:0]  ram_wdata;
    logic                         ram_re;
    logic [ccs_pkg::IDX_W-1:0]    ram_raddr;
    logic [ccs_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [ccs_pkg::ENTRY_W-1:0]  entry;

    logic                         s_fire;
    logic                         out_free;
    logic                         out_load;
    logic                         sweep_end;
    logic                         accumulate;
    logic                         sweep_done;
    logic [ccs_pkg::IDX_W-1:0]    scan_idx;
    logic [ccs_pkg::SUM_W-1:0]    entry_sum;
    logic [ccs_pkg::MARKER_W-1:0] entry_marker;
    ccs_pkg::report_t             report;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign sweep_end  = (scan_channel_reg == ccs_pkg::SCAN_W'(ccs_pkg::NUM_CHANNELS));
    assign scan_idx   = scan_channel_reg[ccs_pkg::IDX_W-1:0];
    assign sweep_done = (sweep_idx_reg == ccs_pkg::IDX_W'(ccs_pkg::NUM_CHANNELS - 1));
    // Ticks between the drive tick and the release tick add to the sum
    assign accumulate = (sample_count_reg != '0) &&
                        (sample_count_reg < ccs_pkg::CNT_W'(ccs_pkg::SAMPLE_TICKS));

    // Never-written entries read as zero sum and zero marker
    assign entry        = rd_valid_reg ? ram_rdata : '0;
    assign entry_sum    = entry[ccs_pkg::SUM_W-1:0];
    assign entry_marker = entry[ccs_pkg::ENTRY_W-1:ccs_pkg::SUM_W];

    ccs_ram #(
        .DATA_W (ccs_pkg::ENTRY_W),
        .DEPTH  (ccs_pkg::NUM_CHANNELS)
    ) u_chan_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re),
        .raddr  (ram_raddr),
        .rdata  (ram_rdata)
    );

    ccs_classify u_classify (
        .sum           (entry_sum),
        .marker_old    (entry_marker),
        .needed        (ccs_pkg::chan_needed(needed_reg, sweep_idx_reg)),
        .ind_enable    (ind_enable_reg),
        .blink_phase   (blink_phase_reg),
        .ok_low_limit  (ok_low_reg),
        .ok_high_limit (ok_high_reg),
        .open_limit    (open_reg),
        .report        (report)
    );

    // Sequencer: read on accept, then modify and write back in ST_SCAN or ST_SWEEP
    always_comb begin
        state_next        = state_reg;
        scan_channel_next = scan_channel_reg;
        sample_count_next = sample_count_reg;
        sweep_idx_next    = sweep_idx_reg;
        blink_phase_next  = blink_phase_reg;
        ram_re            = 1'b0;
        ram_raddr         = scan_idx;
        ram_we            = 1'b0;
        ram_waddr         = scan_idx;
        ram_wdata         = {entry_marker, ccs_pkg::SUM_W'(entry_sum + ccs_pkg::SUM_W'(sample_reg))};
        out_load          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    ram_re = 1'b1;
                    if (sweep_end) begin
                        // Sweep end: flip the blink phase, start at channel 0
                        ram_raddr        = '0;
                        sweep_idx_next   = '0;
                        blink_phase_next = !blink_phase_reg;
                        state_next       = ST_SWEEP;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ram_we   = accumulate;
                    if (sample_count_reg < ccs_pkg::CNT_W'(ccs_pkg::SAMPLE_TICKS)) begin
                        sample_count_next = sample_count_reg + 1'b1;
                    end else begin
                        sample_count_next = '0;
                        scan_channel_next = scan_channel_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                ram_waddr = sweep_idx_reg;
                ram_wdata = {report.marker, ccs_pkg::SUM_W'(0)};
                ram_raddr = sweep_idx_reg + 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    ram_we   = 1'b1;
                    if (sweep_done) begin
                        scan_channel_next = '0;
                        state_next        = ST_IDLE;
                    end else begin
                        ram_re         = 1'b1;
                        sweep_idx_next = sweep_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            scan_channel_reg <= '0;
            sample_count_reg <= '0;
            sweep_idx_reg    <= '0;
            blink_phase_reg  <= 1'b0;
            entry_valid_reg  <= '0;
            rd_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            scan_channel_reg <= scan_channel_next;
            sample_count_reg <= sample_count_next;
            sweep_idx_reg    <= sweep_idx_next;
            blink_phase_reg  <= blink_phase_next;
            // Mark entries as written; an unmarked entry reads as zero
            if (ram_we) begin
                entry_valid_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re) begin
                rd_valid_reg <= entry_valid_reg[ram_raddr];
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the sample of the item in progress
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg <= s_sample_mohm;
        end
    end

    // Output payload: drive update in a scan, one report per channel in a sweep
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (state_reg == ST_SWEEP) begin
                m_kind_reg       <= ccs_pkg::KIND_REPORT;
                m_channel_reg    <= ccs_pkg::chan_field(sweep_idx_reg);
                m_drive_reg      <= 1'b0;
                m_verdict_reg    <= report.verdict;
                m_led_write_reg  <= report.led_write;
                m_led_colour_reg <= report.led_colour;
                m_last_reg       <= sweep_done;
            end else begin
                m_kind_reg       <= ccs_pkg::KIND_DRIVE;
                m_channel_reg    <= ccs_pkg::chan_field(scan_idx);
                m_drive_reg      <= (sample_count_reg <
                                     ccs_pkg::CNT_W'(ccs_pkg::SAMPLE_TICKS));
                m_verdict_reg    <= ccs_pkg::VERDICT_FAULT;
                m_led_write_reg  <= 1'b0;
                m_led_colour_reg <= ccs_pkg::COLOUR_OFF;
                m_last_reg       <= 1'b1;
            end
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_low_reg     <= ccs_pkg::OK_LOW_RST;
            ok_high_reg    <= ccs_pkg::OK_HIGH_RST;
            open_reg       <= ccs_pkg::OPEN_RST;
            needed_reg     <= ccs_pkg::NEEDED_RST;
            ind_enable_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                ccs_pkg::REG_OK_LOW:     ok_low_reg     <= cfg_wdata[ccs_pkg::SAMPLE_W-1:0];
                ccs_pkg::REG_OK_HIGH:    ok_high_reg    <= cfg_wdata[ccs_pkg::SAMPLE_W-1:0];
                ccs_pkg::REG_OPEN:       open_reg       <= cfg_wdata[ccs_pkg::SAMPLE_W-1:0];
                ccs_pkg::REG_NEEDED:     needed_reg     <= cfg_wdata[ccs_pkg::MASK_W-1:0];
                ccs_pkg::REG_IND_ENABLE: ind_enable_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_channel    = m_channel_reg;
    assign m_drive      = m_drive_reg;
    assign m_verdict    = m_verdict_reg;
    assign m_led_write  = m_led_write_reg;
    assign m_led_colour = m_led_colour_reg;
    assign m_last       = m_last_reg;

`ifndef SYNTHESIS
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_channel_reg <= ccs_pkg::SCAN_W'(ccs_pkg::NUM_CHANNELS))
        else $error("scan channel beyond sweep end");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_count_reg <= ccs_pkg::CNT_W'(ccs_pkg::SAMPLE_TICKS))
        else $error("sample count beyond release tick");

    a_ram_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("channel RAM read and write hit the same entry");

    a_sweep_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> sweep_end)
        else $error("sweep running while scan is not at sweep end");

    a_drive_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == ccs_pkg::KIND_DRIVE)) |-> m_last)
        else $error("drive update without last");
`endif

endmodule
